>>> hw/rtl/fdm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fdm_pkg
// Types and constants shared by the differentiation matrix entry cells.
// ---------------------------------------------------------------------------
package fdm_pkg;

   localparam int unsigned MAX_POINTS  = 1024;
   localparam int unsigned COUNT_W     = 11;
   localparam int unsigned INDEX_W     = 10;
   localparam int unsigned SCALE_W     = 32;
   localparam int unsigned VALUE_W     = 32;
   localparam int unsigned MOD_STEPS   = 10;
   localparam int unsigned THETA_STEPS = 42;
   localparam int unsigned FINAL_STEPS = 32;
   localparam int unsigned TERMS       = 11;
   localparam int unsigned RCP_SHIFT   = 34;

   localparam logic [31:0] PI_Q30  = 32'd3373259426;
   localparam logic [30:0] ONE_Q30 = 31'd1073741824;

   localparam logic [0:0] REG_POINT_COUNT  = 1'b0;
   localparam logic [0:0] REG_DOMAIN_SCALE = 1'b1;

   typedef struct packed {
      logic        upper;
      logic        neg;
      logic        zero;
      logic        even;
      logic        half;
      logic        ovf;
   } tag_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] dvd;
      logic [31:0] rem;
      logic [31:0] dvs;
      logic [63:0] quo;
      tag_type     tag;
   } div_lane_type;

   typedef struct packed {
      logic               valid;
      logic [30:0]        x;
      logic [32:0]        ts;
      logic [32:0]        tc;
      logic signed [34:0] s;
      logic signed [34:0] c;
      tag_type            tag;
   } ser_lane_type;

endpackage
`default_nettype wire

>>> hw/rtl/fdm_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fdm_req_if / fdm_rsp_if
// Valid/ready channels for index pairs and matrix entries.
// ---------------------------------------------------------------------------
interface fdm_req_if;
   logic                         valid;
   logic                         ready;
   logic [fdm_pkg::INDEX_W-1:0]  row_index;
   logic [fdm_pkg::INDEX_W-1:0]  col_index;
   modport source (output valid, output row_index, output col_index, input ready);
   modport sink   (input valid, input row_index, input col_index, output ready);
endinterface

interface fdm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [fdm_pkg::VALUE_W-1:0] entry_value;
   modport source (output valid, output entry_value, input ready);
   modport sink   (input valid, input entry_value, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/fourier_diff_matrix_entry.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fourier_diff_matrix_entry
// Entry (j,k) of the periodic Fourier differentiation matrix, Q16.16.
// ---------------------------------------------------------------------------
// Takes one index pair per cycle while no result is stalled and returns one
// entry per pair, in order: 10 cells reduce the index difference mod N, 42
// cells divide the angle by N, 11 four-stage cells sum the sine/cosine
// series, and 32 cells divide the scaled numerator by twice the sine. A
// stalled result freezes the whole row of cells. Write point_count and
// domain_scale only while no transfer is in flight.
module fourier_diff_matrix_entry (
   input  wire            clock,
   input  wire            reset,
   fdm_req_if.sink        req_bus,
   fdm_rsp_if.source      rsp_bus,
   input  wire            csr_write_enable,
   input  wire  [0:0]     csr_index,
   input  wire  [31:0]    csr_write_data
);
   import fdm_pkg::*;

   logic [COUNT_W-1:0] point_count_ff;
   logic [SCALE_W-1:0] domain_scale_ff;
   logic [COUNT_W-1:0] n;
   logic               advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff  <= COUNT_W'(64);
         domain_scale_ff <= SCALE_W'(65536);
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_POINT_COUNT:  point_count_ff  <= csr_write_data[COUNT_W-1:0];
            REG_DOMAIN_SCALE: domain_scale_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (point_count_ff < COUNT_W'(2)) n = COUNT_W'(2);
      else if (point_count_ff > COUNT_W'(MAX_POINTS)) n = COUNT_W'(MAX_POINTS);
      else n = point_count_ff;
   end

   logic                      out_valid_ff;
   logic signed [VALUE_W-1:0] out_value_ff;

   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;

   // index difference mod N
   div_lane_type mod_lane [0:MOD_STEPS];
   logic upper;
   logic [INDEX_W-1:0] diff;

   always_comb begin
      upper = req_bus.col_index >= req_bus.row_index;
      diff  = upper ? req_bus.col_index - req_bus.row_index
                    : req_bus.row_index - req_bus.col_index;
      mod_lane[0]           = '0;
      mod_lane[0].valid     = req_bus.valid && advance;
      mod_lane[0].dvd       = {diff, 54'd0};
      mod_lane[0].dvs       = {21'd0, n};
      mod_lane[0].tag.upper = upper;
   end

   for (genvar gi = 0; gi < MOD_STEPS; gi++) begin : g_mod
      fdm_div_cell u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .lane_i(mod_lane[gi]), .lane_o(mod_lane[gi+1])
      );
   end

   // angle = (pi * min(m, N-m) + N/2) / N
   div_lane_type th_lane [0:THETA_STEPS];
   logic [COUNT_W-1:0] m, nm, mr;
   logic [41:0]        th_num;

   always_comb begin
      m  = mod_lane[MOD_STEPS].rem[COUNT_W-1:0];
      nm = n - m;
      mr = (m > nm) ? nm : m;
      th_num = 42'(PI_Q30 * mr[INDEX_W-1:0]) + {32'd0, n[COUNT_W-1:1]};
      th_lane[0]          = '0;
      th_lane[0].valid    = mod_lane[MOD_STEPS].valid;
      th_lane[0].dvd      = {th_num, 22'd0};
      th_lane[0].dvs      = {21'd0, n};
      th_lane[0].tag      = mod_lane[MOD_STEPS].tag;
      th_lane[0].tag.even = !n[0];
      th_lane[0].tag.zero = (m == '0);
      th_lane[0].tag.half = ({mr, 1'b0} == {1'b0, n});
      th_lane[0].tag.neg  = m[0] ^ (!n[0] && (m > nm)) ^ mod_lane[MOD_STEPS].tag.upper;
   end

   for (genvar gi = 0; gi < THETA_STEPS; gi++) begin : g_theta
      fdm_div_cell u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .lane_i(th_lane[gi]), .lane_o(th_lane[gi+1])
      );
   end

   // sine and cosine series
   ser_lane_type ser_lane [0:TERMS];

   always_comb begin
      ser_lane[0].valid = th_lane[THETA_STEPS].valid;
      ser_lane[0].x     = th_lane[THETA_STEPS].quo[30:0];
      ser_lane[0].ts    = {2'b00, th_lane[THETA_STEPS].quo[30:0]};
      ser_lane[0].tc    = {2'b00, ONE_Q30};
      ser_lane[0].s     = $signed({4'd0, th_lane[THETA_STEPS].quo[30:0]});
      ser_lane[0].c     = $signed({4'd0, ONE_Q30});
      ser_lane[0].tag   = th_lane[THETA_STEPS].tag;
   end

   for (genvar gi = 0; gi < TERMS; gi++) begin : g_term
      localparam int unsigned SDiv = (2*gi+2) * (2*gi+3);
      localparam int unsigned CDiv = (2*gi+1) * (2*gi+2);
      localparam logic [33:0] SRcp = 34'((64'd1 << RCP_SHIFT) / SDiv);
      localparam logic [33:0] CRcp = 34'((64'd1 << RCP_SHIFT) / CDiv);
      fdm_term_cell u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .sin_div(9'(SDiv)), .cos_div(9'(CDiv)),
         .sin_rcp(SRcp), .cos_rcp(CRcp),
         .subtract(gi % 2 == 0),
         .lane_i(ser_lane[gi]), .lane_o(ser_lane[gi+1])
      );
   end

   // numerator product and divisor
   logic        p_valid_ff;
   tag_type     p_tag_ff;
   logic [31:0] p_den_ff;
   logic [62:0] p_prod_ff;
   logic [30:0] c_cl, num;
   logic [31:0] s_cl;

   always_comb begin
      if (ser_lane[TERMS].c[34] || ser_lane[TERMS].tag.half) c_cl = '0;
      else c_cl = ser_lane[TERMS].c[30:0];
      if (ser_lane[TERMS].s[34] || ser_lane[TERMS].s == '0) s_cl = 32'd1;
      else s_cl = ser_lane[TERMS].s[31:0];
      num = ser_lane[TERMS].tag.even ? c_cl : ONE_Q30;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (advance) begin
         p_valid_ff <= ser_lane[TERMS].valid;
         p_tag_ff   <= ser_lane[TERMS].tag;
         p_den_ff   <= {s_cl[30:0], 1'b0};
         p_prod_ff  <= 63'(domain_scale_ff * num);
      end
   end

   div_lane_type fin_lane [0:FINAL_STEPS];

   always_comb begin
      fin_lane[0]         = '0;
      fin_lane[0].valid   = p_valid_ff;
      fin_lane[0].dvd     = {p_prod_ff[31:0], 32'd0};
      fin_lane[0].rem     = {1'b0, p_prod_ff[62:32]};
      fin_lane[0].dvs     = p_den_ff;
      fin_lane[0].tag     = p_tag_ff;
      fin_lane[0].tag.ovf = {1'b0, p_prod_ff[62:32]} >= p_den_ff;
   end

   for (genvar gi = 0; gi < FINAL_STEPS; gi++) begin : g_final
      fdm_div_cell u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .lane_i(fin_lane[gi]), .lane_o(fin_lane[gi+1])
      );
   end

   // saturation and sign
   logic [32:0] mag, limit, mag_sat;
   tag_type     ft;
   logic signed [VALUE_W-1:0] value;

   always_comb begin
      ft      = fin_lane[FINAL_STEPS].tag;
      mag     = {1'b0, fin_lane[FINAL_STEPS].quo[31:0]};
      limit   = ft.neg ? 33'h1_0000_0000 >> 1 : 33'h0_7FFF_FFFF;
      mag_sat = (ft.ovf || mag > limit) ? limit : mag;
      if (ft.zero) value = '0;
      else if (ft.neg) value = $signed(32'(33'd0 - mag_sat));
      else value = $signed(mag_sat[31:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= fin_lane[FINAL_STEPS].valid;
         out_value_ff <= value;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.entry_value = out_value_ff;
endmodule
`default_nettype wire

>>> hw/rtl/fdm_div_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fdm_div_cell
// One restoring division step: shifts in one dividend bit, emits one
// quotient bit, passes the lane on.
// ---------------------------------------------------------------------------
module fdm_div_cell (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   advance,
   input  fdm_pkg::div_lane_type lane_i,
   output fdm_pkg::div_lane_type lane_o
);
   import fdm_pkg::*;

   div_lane_type lane_ff, lane_in;
   logic [32:0]  trial;
   logic [32:0]  diff;

   always_comb begin
      trial   = {lane_i.rem, lane_i.dvd[63]};
      diff    = trial - {1'b0, lane_i.dvs};
      lane_in = lane_i;
      lane_in.dvd = {lane_i.dvd[62:0], 1'b0};
      if (trial >= {1'b0, lane_i.dvs}) begin
         lane_in.rem = diff[31:0];
         lane_in.quo = {lane_i.quo[62:0], 1'b1};
      end else begin
         lane_in.rem = trial[31:0];
         lane_in.quo = {lane_i.quo[62:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (advance) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_o = lane_ff;
endmodule
`default_nettype wire

>>> hw/rtl/fdm_term_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fdm_term_cell
// One Taylor term for sine and cosine: two scaled products, an exact
// division by the factorial factor, accumulation. Four register stages.
// ---------------------------------------------------------------------------
module fdm_term_cell (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   advance,
   input  wire  [8:0]            sin_div,
   input  wire  [8:0]            cos_div,
   input  wire  [33:0]           sin_rcp,
   input  wire  [33:0]           cos_rcp,
   input  wire                   subtract,
   input  fdm_pkg::ser_lane_type lane_i,
   output fdm_pkg::ser_lane_type lane_o
);
   import fdm_pkg::*;

   ser_lane_type a_ff, b_ff, c_ff, lane_ff, lane_in;
   logic [63:0]  psa_ff, pca_ff, psb_ff, pcb_ff;
   logic [32:0]  us_ff, uc_ff;
   logic [66:0]  ms_ff, mc_ff;
   logic [32:0]  qs0, qc0, qs, qc;
   logic [41:0]  rs, rc;

   always_comb begin
      qs0 = ms_ff[RCP_SHIFT +: 33];
      qc0 = mc_ff[RCP_SHIFT +: 33];
      rs  = {9'd0, us_ff} - 42'(qs0 * sin_div);
      rc  = {9'd0, uc_ff} - 42'(qc0 * cos_div);
      qs  = (rs >= {33'd0, sin_div}) ? qs0 + 33'd1 : qs0;
      qc  = (rc >= {33'd0, cos_div}) ? qc0 + 33'd1 : qc0;
      lane_in    = c_ff;
      lane_in.ts = qs;
      lane_in.tc = qc;
      if (subtract) begin
         lane_in.s = c_ff.s - $signed({2'b00, qs});
         lane_in.c = c_ff.c - $signed({2'b00, qc});
      end else begin
         lane_in.s = c_ff.s + $signed({2'b00, qs});
         lane_in.c = c_ff.c + $signed({2'b00, qc});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid    <= 1'b0;
         b_ff.valid    <= 1'b0;
         c_ff.valid    <= 1'b0;
         lane_ff.valid <= 1'b0;
      end else if (advance) begin
         a_ff    <= lane_i;
         psa_ff  <= 64'(lane_i.ts * lane_i.x);
         pca_ff  <= 64'(lane_i.tc * lane_i.x);
         b_ff    <= a_ff;
         psb_ff  <= 64'(psa_ff[62:30] * a_ff.x);
         pcb_ff  <= 64'(pca_ff[62:30] * a_ff.x);
         c_ff    <= b_ff;
         us_ff   <= psb_ff[62:30];
         uc_ff   <= pcb_ff[62:30];
         ms_ff   <= 67'(psb_ff[62:30] * sin_rcp);
         mc_ff   <= 67'(pcb_ff[62:30] * cos_rcp);
         lane_ff <= lane_in;
      end
   end

   assign lane_o = lane_ff;
endmodule
`default_nettype wire

>>> hw/rtl/fdm_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fdm_checker
// Port-level checks on the matrix entry block, bound to the top level.
// ---------------------------------------------------------------------------
module fdm_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [31:0] rsp_value
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_value))
      else $error("result changed while stalled");

   a_req_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input blocked with output free");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result right after reset");
endmodule

bind fourier_diff_matrix_entry fdm_checker u_fdm_checker (
   .clock(clock), .reset(reset),
   .req_ready(req_bus.ready),
   .rsp_valid(rsp_bus.valid), .rsp_ready(rsp_bus.ready),
   .rsp_value(rsp_bus.entry_value)
);
`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives index pairs into fourier_diff_matrix_entry and checks every entry
// against a bit-exact fixed-point predictor or a known value.
// The run goes through several grid sizes and scales, including clamped and
// extreme settings. Both channels idle and stall at random outside the steady phase.
// ---------------------------------------------------------------------------
module testbench;
   import fdm_pkg::*;

   localparam int IDLE_PCT    = 8;
   localparam int DRAIN_WAIT  = 200;
   localparam int STALL_LIMIT = 5000;

   typedef struct {
      logic [INDEX_W-1:0] row;
      logic [INDEX_W-1:0] col;
      bit                 known;
      logic [31:0]        value;
   } pair_row_type;

   logic clock;
   logic reset;
   logic                csr_write_enable;
   logic [0:0]          csr_index;
   logic [31:0]         csr_write_data;

   fdm_req_if req_bus();
   fdm_rsp_if rsp_bus();

   fourier_diff_matrix_entry dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   logic [COUNT_W-1:0] grid_size;
   logic [SCALE_W-1:0] grid_scale;
   logic [31:0]        entry_queue[$];
   int                 fail_count;
   int                 stall_count;
   bit                 steady;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned series_term(longint unsigned t, longint unsigned x,
                                                   longint unsigned div);
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      return t / div;
   endfunction

   function automatic logic [31:0] entry_of(logic [INDEX_W-1:0] j, logic [INDEX_W-1:0] k);
      longint unsigned n, m, mr, theta, ts, tc, num, den, mag, lim;
      longint          s, c;
      bit              upper, even, neg;
      n = 64'(grid_size);
      upper = (k >= j);
      if (n < 2) n = 2;
      if (n > MAX_POINTS) n = MAX_POINTS;
      m = (upper ? longint'(k - j) : longint'(j - k)) % n;
      if (m == 0) return 32'd0;
      even = (n[0] == 1'b0);
      mr = (m > n - m) ? n - m : m;
      theta = (64'(PI_Q30) * mr + n / 2) / n;
      ts = theta;
      tc = 64'(ONE_Q30);
      s = longint'(theta);
      c = longint'(ONE_Q30);
      for (longint unsigned i = 1; i <= TERMS; i++) begin
         ts = series_term(ts, theta, (2 * i) * (2 * i + 1));
         tc = series_term(tc, theta, (2 * i - 1) * (2 * i));
         if (i[0]) begin
            s -= longint'(ts);
            c -= longint'(tc);
         end else begin
            s += longint'(ts);
            c += longint'(tc);
         end
      end
      if (c < 0) c = 0;
      if (2 * mr == n) c = 0;
      if (s <= 0) s = 1;
      num = even ? longint'(c) : 64'(ONE_Q30);
      den = 2 * longint'(s);
      mag = (64'(grid_scale) * num) / den;
      neg = m[0];
      if (even && m > n - m) neg = !neg;
      if (upper) neg = !neg;
      lim = neg ? 64'd2147483648 : 64'd2147483647;
      if (mag > lim) mag = lim;
      return neg ? 32'(-mag) : 32'(mag);
   endfunction

   task automatic csr_write(logic [0:0] idx, logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      if (idx == REG_POINT_COUNT) grid_size = data[COUNT_W-1:0];
      else grid_scale = data;
   endtask

   task automatic set_grid(logic [31:0] size, logic [31:0] scale);
      req_bus.valid <= 1'b0;
      wait (entry_queue.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_write(REG_POINT_COUNT, size);
      csr_write(REG_DOMAIN_SCALE, scale);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_pair(logic [INDEX_W-1:0] j, logic [INDEX_W-1:0] k, bit known,
                            logic [31:0] value);
      if (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.row_index <= j;
      req_bus.col_index <= k;
      do @(posedge clock); while (!req_bus.ready);
      entry_queue.push_back(known ? value : entry_of(j, k));
   endtask

   task automatic random_pairs(int count);
      logic [INDEX_W-1:0] j, k;
      int                 span;
      span = (grid_size < 2) ? 2 : (grid_size > MAX_POINTS) ? MAX_POINTS : grid_size;
      for (int i = 0; i < count; i++) begin
         j = INDEX_W'($urandom_range(span - 1));
         case ($urandom_range(9))
            0, 1: begin
               j = INDEX_W'($urandom);
               k = INDEX_W'($urandom);
            end
            2: k = INDEX_W'(j + $urandom_range(2) - 1);
            3: k = INDEX_W'(j + span / 2);
            default: k = INDEX_W'($urandom_range(span - 1));
         endcase
         send_pair(j, k, 1'b0, '0);
      end
   endtask

   pair_row_type pair_table[] = '{
      '{10'd0,    10'd0,    1'b1, 32'd0},
      '{10'd1023, 10'd1023, 1'b1, 32'd0},
      '{10'd63,   10'd63,   1'b1, 32'd0},
      '{10'd0,    10'd64,   1'b1, 32'd0},
      '{10'd1023, 10'd447,  1'b1, 32'd0},
      '{10'd0,    10'd1,    1'b0, 32'd0},
      '{10'd1,    10'd0,    1'b0, 32'd0},
      '{10'd0,    10'd63,   1'b0, 32'd0},
      '{10'd63,   10'd0,    1'b0, 32'd0},
      '{10'd0,    10'd32,   1'b0, 32'd0},
      '{10'd40,   10'd8,    1'b0, 32'd0},
      '{10'd5,    10'd36,   1'b0, 32'd0},
      '{10'd0,    10'd1023, 1'b0, 32'd0},
      '{10'd1023, 10'd0,    1'b0, 32'd0},
      '{10'd682,  10'd341,  1'b0, 32'd0},
      '{10'd100,  10'd70,   1'b0, 32'd0}
   };

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (entry_queue.size() == 0) begin
               $display("%0t: unexpected entry %h", $time, rsp_bus.entry_value);
               fail_count++;
            end else if (entry_queue[0] !== rsp_bus.entry_value) begin
               $display("%0t: entry_value expected %h actual %h", $time, entry_queue[0],
                        rsp_bus.entry_value);
               fail_count++;
               void'(entry_queue.pop_front());
            end else begin
               void'(entry_queue.pop_front());
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("fourier_diff_matrix_entry: mismatch");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   initial begin
      fail_count       = 0;
      steady           = 1'b0;
      grid_size        = 11'd64;
      grid_scale       = 32'd65536;
      reset            = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.row_index = '0;
      req_bus.col_index = '0;
      csr_write_enable = 1'b0;
      csr_index        = REG_POINT_COUNT;
      csr_write_data   = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (pair_table[i])
         send_pair(pair_table[i].row, pair_table[i].col, pair_table[i].known,
                   pair_table[i].value);
      random_pairs(80);

      set_grid(32'd2, 32'd1);
      random_pairs(60);
      steady = 1'b1;
      set_grid(32'd1024, 32'hFFFF_FFFF);
      send_pair(10'd0, 10'd1, 1'b1, 32'h7FFF_FFFF);
      send_pair(10'd1, 10'd0, 1'b1, 32'h8000_0000);
      random_pairs(100);
      steady = 1'b0;
      set_grid(32'd3, 32'd411775);
      random_pairs(80);
      set_grid(32'd0, 32'd65536);
      random_pairs(60);
      set_grid(32'd2047, 32'd12345678);
      random_pairs(80);
      set_grid(32'd5, 32'd0);
      send_pair(10'd0, 10'd1, 1'b1, 32'd0);
      random_pairs(50);
      set_grid(32'd1023, 32'h8000_0000);
      random_pairs(90);
      set_grid(32'd100 + $urandom_range(400), $urandom);
      random_pairs(90);

      req_bus.valid <= 1'b0;
      wait (entry_queue.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0 && entry_queue.size() == 0)
         $display("fourier_diff_matrix_entry: match");
      else
         $display("fourier_diff_matrix_entry: mismatch");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/fdm_pkg.sv
hw/rtl/fdm_if.sv
hw/rtl/fdm_div_cell.sv
hw/rtl/fdm_term_cell.sv
hw/rtl/fourier_diff_matrix_entry.sv
hw/rtl/fdm_checker.sv
dv/testbench.sv
